// ===== hw/rtl/svf_pkg.sv =====
`timescale 1ns / 1ps

package svf_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int DATA_WIDTH      = 32;
    localparam int COEF_WIDTH      = 32;
    localparam int PROD_WIDTH      = 64;
    // sample/4 minus two 32-bit terms needs two guard bits
    localparam int ACC_WIDTH       = DATA_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FREQ_COEF    = 8'd0,
        REG_DAMPING_COEF = 8'd1
    } svf_reg_index_t;

    typedef struct packed {
        logic [COEF_WIDTH-1:0] freq_coef;
        logic [COEF_WIDTH-1:0] damping_coef;
    } svf_coef_t;

    function automatic logic signed [ACC_WIDTH-1:0] sext_acc(
        input logic signed [DATA_WIDTH-1:0] v
    );
        return {{(ACC_WIDTH - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    endfunction

    // coefficient is unsigned, value signed; product shifted right by 32 with floor
    function automatic logic signed [DATA_WIDTH-1:0] coef_mul(
        input logic [COEF_WIDTH-1:0]        coef,
        input logic signed [DATA_WIDTH-1:0] v
    );
        logic signed [PROD_WIDTH-1:0] p;
        p = $signed({1'b0, coef}) * v;
        return p[PROD_WIDTH-1 -: DATA_WIDTH];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_sample(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic signed [ACC_WIDTH-1:0] r;
        r = v;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== hw/rtl/state_variable_filter_unit.sv =====
`timescale 1ns / 1ps

// state-variable audio filter, one signed sample in, low/band/high-pass out
// sample channel: sample_valid/sample_ready carrying sample_in
// result channel: result_valid/result_ready carrying lowpass_out,
//   bandpass_out and highpass_out, one result per sample
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   the frequency coefficient, index 1 the damping coefficient, other indexes
//   are dropped; cfg_ready is always high, write only while the filter is idle
// a transferred sample waits in the input register; once the result register is
//   free it advances, and the state update registers its result with result_valid
// throughput: one sample per cycle while results are accepted; the state update
//   (three independent 33x32 multiplies on the old state, saturating adds) is a
//   single registered pass per sample
// a stalled result holds its value, and one more sample can still be taken
//   into the input register; the next advances once the result transfers
// reset clears the coefficients, the integrators and all valid flags
module state_variable_filter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] sample_in,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] lowpass_out,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] bandpass_out,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] highpass_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [svf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [svf_pkg::COEF_WIDTH-1:0]        cfg_data
);
    import svf_pkg::*;

    svf_coef_t coef;

    logic                         in_valid_reg, in_valid_next;
    logic signed [DATA_WIDTH-1:0] sample_reg;
    logic                         result_valid_reg, result_valid_next;
    logic                         advance;

    assign advance      = in_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample_valid && sample_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample_in;
        end
    end

    svf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    svf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .sample   (sample_reg),
        .coef     (coef),
        .lowpass  (lowpass_out),
        .bandpass (bandpass_out),
        .highpass (highpass_out)
    );

endmodule

// ===== hw/rtl/svf_regs.sv =====
`timescale 1ns / 1ps

module svf_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [svf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [svf_pkg::COEF_WIDTH-1:0]      cfg_data,
    output svf_pkg::svf_coef_t                  coef
);
    import svf_pkg::*;

    svf_coef_t coef_reg;
    svf_coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FREQ_COEF:    coef_next.freq_coef    = cfg_data;
                REG_DAMPING_COEF: coef_next.damping_coef = cfg_data;
                default:          coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

// ===== hw/rtl/svf_core.sv =====
`timescale 1ns / 1ps

module svf_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] sample,
    input  svf_pkg::svf_coef_t                  coef,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] lowpass,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] bandpass,
    output logic signed [svf_pkg::DATA_WIDTH-1:0] highpass
);
    import svf_pkg::*;

    logic signed [DATA_WIDTH-1:0] low_reg, low_next;
    logic signed [DATA_WIDTH-1:0] band_reg, band_next;
    logic signed [DATA_WIDTH-1:0] high_reg, high_next;

    logic signed [DATA_WIDTH-1:0] damp_prod;
    logic signed [DATA_WIDTH-1:0] low_prod;
    logic signed [DATA_WIDTH-1:0] band_prod;
    logic signed [ACC_WIDTH-1:0]  high_sum;

    // three independent products, all on the state from before this step
    assign damp_prod = coef_mul(coef.damping_coef, band_reg);
    assign low_prod  = coef_mul(coef.freq_coef, band_reg);
    assign band_prod = coef_mul(coef.freq_coef, high_reg);

    assign high_sum = (sext_acc(sample) >>> 2) - sext_acc(damp_prod) - sext_acc(low_reg);

    always_comb
    begin
        low_next  = low_reg;
        band_next = band_reg;
        high_next = high_reg;
        if (advance)
        begin
            low_next  = sat_sample(sext_acc(low_reg) + sext_acc(low_prod));
            band_next = sat_sample(sext_acc(band_reg) + sext_acc(band_prod));
            high_next = sat_sample(high_sum);
        end
    end

    // the filter state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            band_reg <= '0;
            high_reg <= '0;
        end
        else
        begin
            low_reg  <= low_next;
            band_reg <= band_next;
            high_reg <= high_next;
        end
    end

    assign lowpass  = low_reg;
    assign bandpass = band_reg;
    assign highpass = high_reg;

endmodule

// ===== verif/svf_checker.sv =====
`timescale 1ns / 1ps

module svf_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    input  logic                                  sample_ready,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] sample_in,
    input  logic                                  result_valid,
    input  logic                                  result_ready,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] lowpass_out,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] bandpass_out,
    input  logic signed [svf_pkg::DATA_WIDTH-1:0] highpass_out,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [svf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [svf_pkg::COEF_WIDTH-1:0]        cfg_data,
    output int                                    errors,
    output int                                    pending
);
    import svf_pkg::*;

    localparam longint CLAMP_HI     = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint CLAMP_LO     = -CLAMP_HI - 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] lowpass;
        logic signed [DATA_WIDTH-1:0] bandpass;
        logic signed [DATA_WIDTH-1:0] highpass;
    } filter_taps_t;

    logic [COEF_WIDTH-1:0]        freq_coef_q;
    logic [COEF_WIDTH-1:0]        damping_coef_q;
    logic signed [DATA_WIDTH-1:0] band_acc;
    logic signed [DATA_WIDTH-1:0] low_acc;
    logic signed [DATA_WIDTH-1:0] high_prev;
    filter_taps_t                 expected_taps[$];

    // unsigned coefficient times signed value, floor of the product over 2^32
    function automatic longint coef_product(
        input logic [COEF_WIDTH-1:0]        coef,
        input logic signed [DATA_WIDTH-1:0] v
    );
        longint p;
        p = longint'({32'd0, coef}) * longint'(v);
        return p >>> 32;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] clamp_sample(input longint v);
        longint r;
        r = v;
        if (v > CLAMP_HI)
        begin
            r = CLAMP_HI;
        end
        else if (v < CLAMP_LO)
        begin
            r = CLAMP_LO;
        end
        return DATA_WIDTH'(r);
    endfunction

    // all three updates use the state from before this sample
    function automatic filter_taps_t filter_step(input logic signed [DATA_WIDTH-1:0] x);
        filter_taps_t t;
        longint       hp_sum;
        hp_sum     = longint'(x >>> 2) - coef_product(damping_coef_q, band_acc)
                     - longint'(low_acc);
        t.lowpass  = clamp_sample(longint'(low_acc) + coef_product(freq_coef_q, band_acc));
        t.bandpass = clamp_sample(longint'(band_acc) + coef_product(freq_coef_q, high_prev));
        t.highpass = clamp_sample(hp_sum);
        low_acc    = t.lowpass;
        band_acc   = t.bandpass;
        high_prev  = t.highpass;
        return t;
    endfunction

    always @(posedge clk)
    begin : monitor
        filter_taps_t got;
        filter_taps_t want;
        if (!rst_n)
        begin
            freq_coef_q    = '0;
            damping_coef_q = '0;
            band_acc       = '0;
            low_acc        = '0;
            high_prev      = '0;
            errors         = 0;
            expected_taps.delete();
            pending <= 0;
        end
        else
        begin
            // result side first so a transfer on an empty queue is caught
            if (result_valid && result_ready)
            begin
                got = {lowpass_out, bandpass_out, highpass_out};
                if (expected_taps.size() == 0)
                begin
                    errors++;
                    $display({"%0t: result with no sample pending, expected none, ",
                              "actual lp %0d bp %0d hp %0d"},
                             $time, got.lowpass, got.bandpass, got.highpass);
                end
                else
                begin
                    want = expected_taps.pop_front();
                    if (got.lowpass !== want.lowpass || got.bandpass !== want.bandpass ||
                        got.highpass !== want.highpass)
                    begin
                        errors++;
                        $display({"%0t: expected lp %0d bp %0d hp %0d, ",
                                  "actual lp %0d bp %0d hp %0d"},
                                 $time, want.lowpass, want.bandpass, want.highpass,
                                 got.lowpass, got.bandpass, got.highpass);
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                expected_taps.push_back(filter_step(sample_in));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FREQ_COEF:    freq_coef_q    = cfg_data;
                    REG_DAMPING_COEF: damping_coef_q = cfg_data;
                    default:          ;
                endcase
            end
            pending <= expected_taps.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import svf_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 128;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [COEF_WIDTH-1:0]        COEF_MAX     = '1;
    localparam logic [COEF_WIDTH-1:0]        COEF_ZERO    = '0;
    localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN   = 32'sh8000_0000;
    localparam logic [CFG_INDEX_WIDTH-1:0]   UNMAPPED_REG = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0]   TOP_REG      = 8'hFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    logic signed [DATA_WIDTH-1:0]   sample_in    = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0]   lowpass_out;
    logic signed [DATA_WIDTH-1:0]   bandpass_out;
    logic signed [DATA_WIDTH-1:0]   highpass_out;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]     cfg_index    = '0;
    logic [COEF_WIDTH-1:0]          cfg_data     = '0;

    int   mismatch_count;
    int   samples_in_flight;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_taken     = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    state_variable_filter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .lowpass_out  (lowpass_out),
        .bandpass_out (bandpass_out),
        .highpass_out (highpass_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    svf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .lowpass_out  (lowpass_out),
        .bandpass_out (bandpass_out),
        .highpass_out (highpass_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (mismatch_count),
        .pending      (samples_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result sink: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken   <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
        begin
            if (!hold_req)
            begin
                hold_taken <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                      (cfg_valid && cfg_ready)))
        begin
            quiet_cycles <= 0;
        end
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[state_variable_filter_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 86;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 86;
            end
            default:
            begin
                send_idle_pct = 35;
                recv_stall_pct <= 35;
            end
        endcase
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [COEF_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    task automatic set_coefs(input logic [COEF_WIDTH-1:0] freq,
                             input logic [COEF_WIDTH-1:0] damp);
        write_reg(REG_FREQ_COEF, freq);
        write_reg(REG_DAMPING_COEF, damp);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= s;
        do
            @(posedge clk);
        while (!(sample_valid && sample_ready));
    endtask

    // the in-flight count is registered and lags the transfers, so wait on the clock before polling it
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (samples_in_flight != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
        logic signed [DATA_WIDTH-1:0] s;
        s = $signed($urandom);
        case ($urandom_range(9))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2:       s = $signed($urandom_range(16)) - 8;
            3, 4, 5: s = s >>> $urandom_range(24);
            default: ;
        endcase
        return s;
    endfunction

    initial
    begin : stimulus
        logic [COEF_WIDTH-1:0] freq;
        logic [COEF_WIDTH-1:0] damp;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(IDLE_NONE);

        // drive the low-pass integrator into positive then negative saturation, the band-pass one into negative
        set_coefs(COEF_MAX, COEF_ZERO);
        repeat (5) send_sample(SAMPLE_MAX);
        repeat (6) send_sample(SAMPLE_MIN);
        drain_results();

        // writes to unmapped indexes, which must be dropped; both coefficients are set again after them
        write_reg(UNMAPPED_REG, $urandom);
        write_reg(TOP_REG, $urandom);
        set_coefs(COEF_MAX, COEF_MAX);
        // floor rounding of the quarter-scaled input, then high-pass clamping
        send_sample(32'sd0);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(-32'sd3);
        send_sample(-32'sd4);
        send_sample(32'sd3);
        send_sample(32'sd4);
        repeat (2) send_sample(SAMPLE_MAX);
        repeat (2) send_sample(SAMPLE_MIN);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    freq = COEF_ZERO;
                    damp = COEF_ZERO;
                end
                1:
                begin
                    freq = COEF_MAX;
                    damp = COEF_MAX;
                end
                2:
                begin
                    freq = COEF_ZERO;
                    damp = COEF_MAX;
                end
                3:
                begin
                    freq = COEF_MAX;
                    damp = COEF_ZERO;
                end
                7:
                begin
                    freq = $urandom;
                    damp = $urandom;
                end
                default:
                begin
                    // typical audio settings: low cutoff, any damping
                    freq = $urandom_range(32'h1000_0000, 0);
                    damp = $urandom;
                end
            endcase
            if (p == 5)
            begin
                write_reg(CFG_INDEX_WIDTH'($urandom_range(255, 2)), $urandom);
            end
            set_coefs(freq, damp);
            set_idle(idle_mode_t'(p % 4));
            if (p == PRESSURE_PHASE)
            begin
                hold_req <= 1'b1;
            end
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            drain_results();
            hold_req <= 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[state_variable_filter_unit] OK");
        end
        else
        begin
            $display("[state_variable_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
